// ===== hw/rtl/nia_pkg.sv =====
// ---------------------------------------------------------------------------
// nia_pkg: shared types and constants of the node identifier allocator
// Operation codes, bitmap word geometry and the transaction structs.
// ---------------------------------------------------------------------------
package nia_pkg;

	localparam int WORD_W   = 64;
	localparam int WORD_LSB = 6;
	localparam int ID_W     = 10;

	localparam logic [1:0] OP_MARK       = 2'd0;
	localparam logic [1:0] OP_RELEASE    = 2'd1;
	localparam logic [1:0] OP_ALLOC_DATA = 2'd2;
	localparam logic [1:0] OP_ALLOC_SYS  = 2'd3;

	typedef struct packed {
		logic [1:0]      operation;
		logic [ID_W-1:0] node_id;
	} nia_cmd_t;

	typedef struct packed {
		logic [ID_W-1:0] granted_id;
		logic            pool_full;
	} nia_res_t;

	typedef struct packed {
		logic [WORD_W-1:0]   word;
		logic                lo_hit;
		logic [WORD_LSB-1:0] lo_bit;
		logic                hi_hit;
		logic [WORD_LSB-1:0] hi_bit;
	} nia_find_req_t;

	typedef struct packed {
		logic                found;
		logic [WORD_LSB-1:0] bit_idx;
	} nia_find_rsp_t;

endpackage

// ===== hw/rtl/nia_ram.sv =====
// ---------------------------------------------------------------------------
// nia_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module nia_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/nia_find.sv =====
// ---------------------------------------------------------------------------
// nia_find: free slot search in one bitmap word
// Masks the word to the scanned range and picks the lowest clear bit.
// ---------------------------------------------------------------------------
module nia_find
	import nia_pkg::*;
(
	input  nia_find_req_t req,
	output nia_find_rsp_t rsp
);

	logic [WORD_W-1:0] lo_mask;
	logic [WORD_W-1:0] hi_mask;
	logic [WORD_W-1:0] avail;

	always_comb begin
		lo_mask = req.lo_hit ? ({WORD_W{1'b1}} << req.lo_bit) : {WORD_W{1'b1}};
		hi_mask = req.hi_hit ? ({WORD_W{1'b1}} >> (WORD_LSB'(WORD_W - 1) - req.hi_bit))
		                     : {WORD_W{1'b1}};
		avail   = ~req.word & lo_mask & hi_mask;
	end

	always_comb begin
		rsp.found   = |avail;
		rsp.bit_idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (avail[i]) begin
				rsp.bit_idx = WORD_LSB'(i);
			end
		end
	end

endmodule

// ===== hw/rtl/node_id_allocator_top.sv =====
// ---------------------------------------------------------------------------
// node_id_allocator_top: next-fit node identifier allocator
// Used-identifier bitmap in RAM with a system and a data next-fit cursor.
// ---------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a rising edge with start high and busy low;
//   cmd carries the operation and node_id. Every transaction returns one
//   result: done is high for exactly one cycle with result valid, and the
//   receiver cannot hold it off.
//   The bitmap lives in one RAM of 64-bit words with a registered read.
//   Mark used and release read, modify and write one word in the decode
//   and read-modify-write states; node_id outside the map skips the write.
//   Allocate streams the pool's words from the cursor, one read per cycle,
//   wrapping to the pool start; the words read are at most the pool's
//   words plus one, up to 16 for the full 960-identifier data pool.
//   busy stays high from the accepting edge until the result is out, so one
//   transaction is in flight at a time.
//   After reset the block clears the bitmap one word per cycle, all of its
//   words (16 by default), with busy high; cursors return to the pool starts.
// ---------------------------------------------------------------------------
module node_id_allocator_top
	import nia_pkg::*;
#(
	parameter int ID_SPACE   = 1024,
	parameter int SYS_FIRST  = 1,
	parameter int SYS_LAST   = 63,
	parameter int DATA_FIRST = 64,
	parameter int DATA_LAST  = 1023
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  nia_cmd_t cmd,
	output logic     done,
	output nia_res_t result
);

	localparam int WORDS = (ID_SPACE + WORD_W - 1) / WORD_W;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int MAX_A = (ID_SPACE > DATA_LAST + 1) ? ID_SPACE : DATA_LAST + 1;
	localparam int MAX_B = (MAX_A > SYS_LAST + 1) ? MAX_A : SYS_LAST + 1;
	localparam int MAX_C = (MAX_B > DATA_FIRST) ? MAX_B : DATA_FIRST;
	localparam int MAX_V = (MAX_C > 1024) ? MAX_C : 1024;
	localparam int CW    = $clog2(MAX_V + 1);

	localparam logic [CW-1:0] DF_C  = CW'(DATA_FIRST);
	localparam logic [CW-1:0] DL_C  = CW'(DATA_LAST);
	localparam logic [CW-1:0] SF_C  = CW'(SYS_FIRST);
	localparam logic [CW-1:0] SL_C  = CW'(SYS_LAST);
	localparam logic [CW-1:0] LIM_C = CW'(ID_SPACE - 1);

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_DECODE = 5'b00100,
		S_RMW    = 5'b01000,
		S_SCAN   = 5'b10000
	} state_t;

	function automatic logic [AW-1:0] word_of(input logic [CW-1:0] v);
		logic [CW-1:0] s;
		s = v >> WORD_LSB;
		return s[AW-1:0];
	endfunction

	state_t          state_q;
	logic [AW-1:0]   clr_q;
	nia_cmd_t        cmd_q;
	logic [CW-1:0]   data_cur_q;
	logic [CW-1:0]   sys_cur_q;
	logic [CW-1:0]   c_q;
	logic [CW-1:0]   a_lo_q;
	logic [CW-1:0]   a_hi_q;
	logic [CW-1:0]   b_lo_q;
	logic [CW-1:0]   b_hi_q;
	logic            b_ok_q;
	logic            iss_act_q;
	logic            iss_seg_q;
	logic [AW-1:0]   iss_w_q;
	logic            chk_v_s1;
	logic            chk_seg_s1;
	logic            chk_last_s1;
	logic [AW-1:0]   chk_w_s1;
	logic            done_q;
	nia_res_t        res_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	nia_find_req_t   find_req;
	nia_find_rsp_t   find_rsp;

	logic            alloc_data;
	logic [CW-1:0]   pf;
	logic [CW-1:0]   pl;
	logic [CW-1:0]   cur;
	logic [CW-1:0]   c_n;
	logic [CW-1:0]   a_hi_n;
	logic [CW-1:0]   b_hi_n;
	logic            a_ok_n;
	logic            b_ok_n;
	logic [CW-1:0]   fin;
	logic [CW-1:0]   id_ext;
	logic            id_in;
	logic [AW-1:0]   id_w;
	logic [WORD_W-1:0] id_bit;
	logic [CW-1:0]   mk_data;
	logic [CW-1:0]   mk_sys;
	logic [CW-1:0]   lo_c;
	logic [CW-1:0]   hi_c;
	logic [CW-1:0]   g;
	logic [CW-1:0]   g_data;
	logic [CW-1:0]   g_sys;
	logic            iss_end;
	logic            grant;

	// pool bounds and segment setup
	always_comb begin
		alloc_data = (cmd_q.operation == OP_ALLOC_DATA);
		pf  = alloc_data ? DF_C : SF_C;
		pl  = alloc_data ? DL_C : SL_C;
		cur = alloc_data ? data_cur_q : sys_cur_q;
		c_n = (cur > pl || cur < pf) ? pf : cur;
		a_hi_n = (pl < LIM_C) ? pl : LIM_C;
		a_ok_n = (c_n <= a_hi_n);
		b_hi_n = ((c_n - 1'b1) < LIM_C) ? (c_n - 1'b1) : LIM_C;
		b_ok_n = (c_n > pf) && (pf <= b_hi_n);
		fin    = (c_q == pf) ? (pl + 1'b1) : c_q;
	end

	// mark used / release operand
	always_comb begin
		id_ext  = CW'(cmd_q.node_id);
		id_in   = (id_ext < CW'(ID_SPACE));
		id_w    = word_of(id_ext);
		id_bit  = WORD_W'(1) << cmd_q.node_id[WORD_LSB-1:0];
		mk_data = data_cur_q;
		mk_sys  = sys_cur_q;
		if (id_ext >= DF_C) begin
			if (data_cur_q <= id_ext) begin
				mk_data = id_ext + 1'b1;
			end
		end else if (sys_cur_q <= id_ext) begin
			mk_sys = id_ext + 1'b1;
		end
	end

	// scan check
	always_comb begin
		lo_c = chk_seg_s1 ? b_lo_q : a_lo_q;
		hi_c = chk_seg_s1 ? b_hi_q : a_hi_q;
		find_req.word   = ram_rdata;
		find_req.lo_hit = (chk_w_s1 == word_of(lo_c));
		find_req.lo_bit = lo_c[WORD_LSB-1:0];
		find_req.hi_hit = (chk_w_s1 == word_of(hi_c));
		find_req.hi_bit = hi_c[WORD_LSB-1:0];
		iss_end = (iss_w_q == word_of(iss_seg_q ? b_hi_q : a_hi_q));
		grant   = (state_q == S_SCAN) && chk_v_s1 && find_rsp.found;
		g = (CW'(chk_w_s1) << WORD_LSB) | CW'(find_rsp.bit_idx);
		g_data = alloc_data ? g : data_cur_q;
		g_sys  = alloc_data ? sys_cur_q : g;
		if (g >= DF_C) begin
			if (g_data <= g) begin
				g_data = g + 1'b1;
			end
		end else if (g_sys <= g) begin
			g_sys = g + 1'b1;
		end
	end

	nia_find u_find (
		.req (find_req),
		.rsp (find_rsp)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_raddr = iss_w_q;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_DECODE: begin
				ram_raddr = id_w;
			end
			S_RMW: begin
				ram_we    = 1'b1;
				ram_waddr = id_w;
				ram_wdata = (cmd_q.operation == OP_MARK) ? (ram_rdata | id_bit)
				                                         : (ram_rdata & ~id_bit);
			end
			S_SCAN: begin
				ram_we    = grant;
				ram_waddr = chk_w_s1;
				ram_wdata = ram_rdata | (WORD_W'(1) << find_rsp.bit_idx);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	nia_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			data_cur_q  <= DF_C;
			sys_cur_q   <= SF_C;
			iss_act_q   <= 1'b0;
			chk_v_s1    <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					res_q <= '0;
					if (cmd_q.operation == OP_MARK || cmd_q.operation == OP_RELEASE) begin
						if (id_in) begin
							state_q <= S_RMW;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (pl < pf) begin
						res_q.pool_full <= 1'b1;
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
					end else if (!a_ok_n && !b_ok_n) begin
						res_q.pool_full <= 1'b1;
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
						if (alloc_data) begin
							data_cur_q <= (c_n == pf) ? (pl + 1'b1) : c_n;
						end else begin
							sys_cur_q <= (c_n == pf) ? (pl + 1'b1) : c_n;
						end
					end else begin
						c_q       <= c_n;
						a_lo_q    <= c_n;
						a_hi_q    <= a_hi_n;
						b_lo_q    <= pf;
						b_hi_q    <= b_hi_n;
						b_ok_q    <= b_ok_n;
						iss_act_q <= 1'b1;
						iss_seg_q <= !a_ok_n;
						iss_w_q   <= a_ok_n ? word_of(c_n) : word_of(pf);
						chk_v_s1  <= 1'b0;
						state_q   <= S_SCAN;
					end
				end
				S_RMW: begin
					if (cmd_q.operation == OP_MARK) begin
						data_cur_q <= mk_data;
						sys_cur_q  <= mk_sys;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					// advance the read stream
					chk_v_s1    <= iss_act_q;
					chk_seg_s1  <= iss_seg_q;
					chk_w_s1    <= iss_w_q;
					chk_last_s1 <= iss_end && (iss_seg_q || !b_ok_q);
					if (iss_end) begin
						if (!iss_seg_q && b_ok_q) begin
							iss_seg_q <= 1'b1;
							iss_w_q   <= word_of(b_lo_q);
						end else begin
							iss_act_q <= 1'b0;
						end
					end else begin
						iss_w_q <= iss_w_q + 1'b1;
					end
					if (grant) begin
						data_cur_q       <= g_data;
						sys_cur_q        <= g_sys;
						res_q.granted_id <= g[ID_W-1:0];
						res_q.pool_full  <= 1'b0;
						done_q           <= 1'b1;
						iss_act_q        <= 1'b0;
						chk_v_s1         <= 1'b0;
						state_q          <= S_IDLE;
					end else if (chk_v_s1 && chk_last_s1) begin
						if (alloc_data) begin
							data_cur_q <= fin;
						end else begin
							sys_cur_q <= fin;
						end
						res_q.granted_id <= '0;
						res_q.pool_full  <= 1'b1;
						done_q           <= 1'b1;
						iss_act_q        <= 1'b0;
						chk_v_s1         <= 1'b0;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	a_full_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.pool_full && result.granted_id != '0))
		else $error("pool_full reported with a granted identifier");

	a_grant_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		grant |-> (g >= pf && g <= pl && g <= LIM_C))
		else $error("granted identifier outside its pool");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DECODE) |-> !ram_we)
		else $error("bitmap written with no transaction at work");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_DECODE || state_q == S_RMW || state_q == S_SCAN))
		else $error("result strobe without a transaction");

	a_busy_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (busy && !done))
		else $error("transaction possible during bitmap clear");

endmodule

// ===== tb/tb_node_id_allocator_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_node_id_allocator_top: self-checking bench of the node identifier allocator
// Starts with a directed table of transactions, typed results where obvious.
// Random traffic with system-pool exhaustion and release runs follows, then
// a full data-pool fill; the sender idles at varying rates across phases.
// Untyped results meet an in-bench next-fit model of bitmap and both cursors.
// ---------------------------------------------------------------------------
module tb_node_id_allocator_top;
	import nia_pkg::*;

	localparam int ID_SPACE   = 1024;
	localparam int SYS_FIRST  = 1;
	localparam int SYS_LAST   = 63;
	localparam int DATA_FIRST = 64;
	localparam int DATA_LAST  = 1023;

	typedef struct packed {
		nia_cmd_t c;
		logic     typed;
		nia_res_t want;
	} probe_row_t;

	localparam int N_ROWS = 22;
	localparam probe_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{'{OP_ALLOC_SYS,  10'h000}, 1'b1, '{10'd1,  1'b0}},
		'{'{OP_ALLOC_DATA, 10'h3FF}, 1'b1, '{10'd64, 1'b0}},
		'{'{OP_MARK,       10'd0},   1'b1, '{10'd0,  1'b0}},
		'{'{OP_MARK,       10'd1023},1'b1, '{10'd0,  1'b0}},
		'{'{OP_ALLOC_DATA, 10'h000}, 1'b0, '{10'd0,  1'b0}},
		'{'{OP_RELEASE,    10'd64},  1'b1, '{10'd0,  1'b0}},
		'{'{OP_ALLOC_DATA, 10'h155}, 1'b0, '{10'd0,  1'b0}},
		'{'{OP_MARK,       10'd63},  1'b1, '{10'd0,  1'b0}},
		'{'{OP_ALLOC_SYS,  10'h2AA}, 1'b0, '{10'd0,  1'b0}},
		'{'{OP_MARK,       10'd2},   1'b1, '{10'd0,  1'b0}},
		'{'{OP_RELEASE,    10'd2},   1'b1, '{10'd0,  1'b0}},
		'{'{OP_RELEASE,    10'd2},   1'b1, '{10'd0,  1'b0}},
		'{'{OP_RELEASE,    10'd1023},1'b1, '{10'd0,  1'b0}},
		'{'{OP_RELEASE,    10'd0},   1'b1, '{10'd0,  1'b0}},
		'{'{OP_MARK,       10'd512}, 1'b1, '{10'd0,  1'b0}},
		'{'{OP_MARK,       10'd100}, 1'b1, '{10'd0,  1'b0}},
		'{'{OP_ALLOC_DATA, 10'h3FF}, 1'b0, '{10'd0,  1'b0}},
		'{'{OP_RELEASE,    10'h155}, 1'b1, '{10'd0,  1'b0}},
		'{'{OP_MARK,       10'h2AA}, 1'b1, '{10'd0,  1'b0}},
		'{'{OP_ALLOC_SYS,  10'h155}, 1'b0, '{10'd0,  1'b0}},
		'{'{OP_RELEASE,    10'd512}, 1'b1, '{10'd0,  1'b0}},
		'{'{OP_ALLOC_DATA, 10'h000}, 1'b0, '{10'd0,  1'b0}}
	};

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	nia_cmd_t cmd;
	logic     done;
	nia_res_t result;

	bit          id_taken [ID_SPACE];
	logic [10:0] data_ptr;
	logic [10:0] sys_ptr;

	nia_res_t    grant_queue [$];
	int unsigned mismatches;
	int unsigned sender_idle_pct;

	node_id_allocator_top #(
		.ID_SPACE  (ID_SPACE),
		.SYS_FIRST (SYS_FIRST),
		.SYS_LAST  (SYS_LAST),
		.DATA_FIRST(DATA_FIRST),
		.DATA_LAST (DATA_LAST)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.done  (done),
		.result(result)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic void claim_id(input int unsigned id);
		if (id >= ID_SPACE)
			return;
		id_taken[id] = 1'b1;
		if (id >= DATA_FIRST) begin
			if (data_ptr <= id)
				data_ptr = 11'(id + 1);
		end else if (sys_ptr <= id) begin
			sys_ptr = 11'(id + 1);
		end
	endfunction

	function automatic nia_res_t scan_pool(input bit sys_pool);
		int unsigned first;
		int unsigned last;
		int unsigned ptr;
		int unsigned n;
		bit          found;
		nia_res_t    r;
		first = sys_pool ? SYS_FIRST : DATA_FIRST;
		last  = sys_pool ? SYS_LAST : DATA_LAST;
		ptr   = 32'(sys_pool ? sys_ptr : data_ptr);
		found = 1'b0;
		r.granted_id = '0;
		r.pool_full  = 1'b1;
		if (last >= first) begin
			for (n = 0; n <= last - first && !found; n++) begin
				if (ptr > last || ptr < first)
					ptr = first;
				if (ptr < ID_SPACE && !id_taken[ptr])
					found = 1'b1;
				else
					ptr++;
			end
		end
		if (sys_pool)
			sys_ptr = 11'(ptr);
		else
			data_ptr = 11'(ptr);
		if (found) begin
			r.granted_id = ID_W'(ptr);
			r.pool_full  = 1'b0;
			claim_id(ptr);
		end
		return r;
	endfunction

	function automatic nia_res_t predict_outcome(input nia_cmd_t c);
		nia_res_t r;
		r = '0;
		case (c.operation)
			OP_MARK: claim_id(32'(c.node_id));
			OP_RELEASE: begin
				if (c.node_id < ID_SPACE)
					id_taken[c.node_id] = 1'b0;
			end
			OP_ALLOC_DATA: r = scan_pool(1'b0);
			default: r = scan_pool(1'b1);
		endcase
		return r;
	endfunction

	task automatic issue(input nia_cmd_t c, input bit typed, input nia_res_t want);
		int unsigned gap;
		nia_res_t    predicted;
		gap = 0;
		while (gap < 60 && $urandom_range(0, 99) < sender_idle_pct)
			gap++;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		predicted = predict_outcome(c);
		grant_queue = {grant_queue, (typed ? want : predicted)};
	endtask

	task automatic issue_op(input logic [1:0] op, input logic [ID_W-1:0] id);
		nia_cmd_t c;
		c.operation = op;
		c.node_id   = id;
		issue(c, 1'b0, '0);
	endtask

	task automatic random_traffic(input int unsigned count);
		int unsigned sent;
		int unsigned pick;
		int unsigned run_len;
		logic [ID_W-1:0] base;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				// exhaust the system pool
				repeat (SYS_LAST - SYS_FIRST + 2)
					issue_op(OP_ALLOC_SYS, ID_W'($urandom));
				sent += SYS_LAST - SYS_FIRST + 2;
			end else if (pick < 6) begin
				base    = ID_W'($urandom);
				run_len = $urandom_range(8, 40);
				for (int unsigned k = 0; k < run_len; k++)
					issue_op(OP_RELEASE, base + ID_W'(k));
				sent += run_len;
			end else begin
				if (pick < 36)
					issue_op(OP_ALLOC_DATA, ID_W'($urandom));
				else if (pick < 56)
					issue_op(OP_ALLOC_SYS, ID_W'($urandom));
				else if (pick < 78)
					issue_op(OP_MARK, ID_W'($urandom));
				else if ($urandom_range(0, 1) != 0)
					issue_op(OP_RELEASE, ID_W'($urandom_range(0, DATA_FIRST - 1)));
				else
					issue_op(OP_RELEASE, ID_W'($urandom));
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		nia_res_t want;
		if (arst_n && done === 1'b1) begin
			if (grant_queue.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: granted_id=%0d pool_full=%0b",
						result.granted_id, result.pool_full);
				mismatches++;
			end else begin
				want = grant_queue.pop_front();
				if (result.granted_id !== want.granted_id
						|| result.pool_full !== want.pool_full) begin
					if (mismatches < 10)
						$display("mismatch: granted_id exp %0d got %0d, pool_full exp %0b got %0b",
							want.granted_id, result.granted_id, want.pool_full,
							result.pool_full);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		foreach (id_taken[i])
			id_taken[i] = 1'b0;
		data_ptr        = 11'(DATA_FIRST);
		sys_ptr         = 11'(SYS_FIRST);
		mismatches      = 0;
		sender_idle_pct = 36;
		arst_n          = 1'b0;
		start           = 1'b0;
		cmd             = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_ROWS; r++)
			issue(DIRECTED_ROWS[r].c, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

		random_traffic(400);

		sender_idle_pct = 84;
		random_traffic(250);

		sender_idle_pct = 0;
		// fill the data pool until it reports full
		repeat (DATA_LAST - DATA_FIRST + 2)
			issue_op(OP_ALLOC_DATA, ID_W'($urandom));
		random_traffic(100);

		start <= 1'b0;
		while (grant_queue.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/nia_pkg.sv
hw/rtl/nia_ram.sv
hw/rtl/nia_find.sv
hw/rtl/node_id_allocator_top.sv
tb/tb_node_id_allocator_top.sv
